// ----- rtl/core/afsi_pkg.sv -----
// ----------------------------------------------------------------------------
// afsi_pkg: shared constants, types and table builders for the field-sync
// inserter. The sync segment tables are built at elaboration time.
// ----------------------------------------------------------------------------
`default_nettype none

package afsi_pkg;

  localparam int GROUP_SYMBOLS      = 16;
  localparam int SYM_BITS           = 3;
  localparam int WORD_BITS          = GROUP_SYMBOLS * SYM_BITS;
  localparam int SEG_GROUPS         = 52;
  localparam int SEG_SYMBOLS        = SEG_GROUPS * GROUP_SYMBOLS;
  localparam int GROUP_BITS         = 6;
  localparam int TAIL_SYMS_DEF      = 12;
  localparam int PN511_LEN          = 511;
  localparam int PN63_LEN           = 63;
  localparam int MODE_LEN           = 24;
  localparam int SYNC_LEN           = 4;
  localparam int TAIL_REGION        = 104;

  // The middle PN63 sits right after segment sync, PN511 and the first PN63.
  localparam int INV_FIRST = SYNC_LEN + PN511_LEN + PN63_LEN;
  localparam int INV_LAST  = INV_FIRST + PN63_LEN - 1;

  localparam logic [SYM_BITS-1:0] LEVEL_ZERO = 3'd1;
  localparam logic [SYM_BITS-1:0] LEVEL_ONE  = 3'd6;

  // Mode word, first transmitted bit in the most significant position.
  localparam logic [MODE_LEN-1:0] MODE_WORD = 24'b0000_1010_0101_1111_0101_1010;

  localparam logic [GROUP_BITS-1:0] LAST_GROUP = GROUP_BITS'(SEG_GROUPS - 1);

  typedef struct packed {
    logic [GROUP_BITS-1:0] group;
    logic                  inv;
  } sync_req_t;

  // Binary content of the whole sync segment with no inversion. The kept
  // tail symbols are not binary and are left as zero here.
  function automatic logic [SEG_SYMBOLS-1:0] sync_bits(int saved);
    logic [PN511_LEN-1:0]   pn511;
    logic [PN63_LEN-1:0]    pn63;
    logic [SEG_SYMBOLS-1:0] seg;
    int                     i;
    pn511 = '0;
    pn63  = '0;
    seg   = '0;
    pn511[7] = 1'b1;
    for (int m = 9; m < PN511_LEN; m++) begin
      pn511[m] = pn511[m-2] ^ pn511[m-3] ^ pn511[m-5] ^ pn511[m-6] ^ pn511[m-8] ^ pn511[m-9];
    end
    pn63[0] = 1'b1;
    pn63[1] = 1'b1;
    pn63[2] = 1'b1;
    pn63[5] = 1'b1;
    for (int m = 6; m < PN63_LEN; m++) begin
      pn63[m] = pn63[m-5] ^ pn63[m-6];
    end
    seg[0] = 1'b1;
    seg[3] = 1'b1;
    i = SYNC_LEN;
    for (int j = 0; j < PN511_LEN; j++) begin
      seg[i] = pn511[j];
      i++;
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < PN63_LEN; j++) begin
        seg[i] = pn63[j];
        i++;
      end
    end
    for (int j = 0; j < MODE_LEN; j++) begin
      seg[i] = MODE_WORD[MODE_LEN-1-j];
      i++;
    end
    for (int j = 0; j < TAIL_REGION - saved; j++) begin
      seg[i] = pn63[j % PN63_LEN];
      i++;
    end
    return seg;
  endfunction

  // Bits seen by one lane, one per group of the sync segment.
  function automatic logic [SEG_GROUPS-1:0] lane_column(int saved, int lane);
    logic [SEG_SYMBOLS-1:0] seg;
    logic [SEG_GROUPS-1:0]  col;
    seg = sync_bits(saved);
    col = '0;
    for (int g = 0; g < SEG_GROUPS; g++) begin
      col[g] = seg[g*GROUP_SYMBOLS + lane];
    end
    return col;
  endfunction

  // Marks the groups in which a lane falls inside the middle PN63.
  function automatic logic [SEG_GROUPS-1:0] inv_column(int lane);
    logic [SEG_GROUPS-1:0] col;
    int                    p;
    col = '0;
    for (int g = 0; g < SEG_GROUPS; g++) begin
      p = g*GROUP_SYMBOLS + lane;
      col[g] = (p >= INV_FIRST) && (p <= INV_LAST);
    end
    return col;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/afsi_lane.sv -----
// ----------------------------------------------------------------------------
// afsi_lane: one symbol position of a sync group.
// Looks up the lane's binary value for the requested group, applies the
// field-two inversion and maps it to a level.
// ----------------------------------------------------------------------------
`default_nettype none

module afsi_lane #(
  parameter int LANE      = 0,
  parameter int TAIL_SYMS = afsi_pkg::TAIL_SYMS_DEF
) (
  input  afsi_pkg::sync_req_t           req,
  output logic [afsi_pkg::SYM_BITS-1:0] symbol
);

  localparam logic [afsi_pkg::SEG_GROUPS-1:0] BIT_COL =
    afsi_pkg::lane_column(TAIL_SYMS, LANE);
  localparam logic [afsi_pkg::SEG_GROUPS-1:0] INV_COL = afsi_pkg::inv_column(LANE);

  logic bit_val;

  assign bit_val = BIT_COL[req.group] ^ (req.inv & INV_COL[req.group]);
  assign symbol  = bit_val ? afsi_pkg::LEVEL_ONE : afsi_pkg::LEVEL_ZERO;

endmodule

`default_nettype wire

// ----- rtl/core/afsi_sync_gen.sv -----
// ----------------------------------------------------------------------------
// afsi_sync_gen: sync group generator.
// Sixteen lanes work side by side and their symbols are merged into one
// packed group word, with the kept tail symbols in the top of the last group.
// ----------------------------------------------------------------------------
`default_nettype none

module afsi_sync_gen #(
  parameter int TAIL_SYMS = afsi_pkg::TAIL_SYMS_DEF
) (
  input  afsi_pkg::sync_req_t                     req,
  input  logic [afsi_pkg::SYM_BITS*TAIL_SYMS-1:0] tail,
  output logic [afsi_pkg::WORD_BITS-1:0]          word
);

  localparam int TAIL_FIRST_LANE = afsi_pkg::GROUP_SYMBOLS - TAIL_SYMS;

  logic [afsi_pkg::SYM_BITS-1:0] lane_sym [afsi_pkg::GROUP_SYMBOLS];

  generate
    for (genvar k = 0; k < afsi_pkg::GROUP_SYMBOLS; k++) begin : g_lane
      afsi_lane #(
        .LANE      (k),
        .TAIL_SYMS (TAIL_SYMS)
      ) u_lane (
        .req    (req),
        .symbol (lane_sym[k])
      );
      if (k >= TAIL_FIRST_LANE) begin : g_tail
        assign word[afsi_pkg::SYM_BITS*k +: afsi_pkg::SYM_BITS] =
          (req.group == afsi_pkg::LAST_GROUP) ?
          tail[afsi_pkg::SYM_BITS*(k-TAIL_FIRST_LANE) +: afsi_pkg::SYM_BITS] : lane_sym[k];
      end else begin : g_plain
        assign word[afsi_pkg::SYM_BITS*k +: afsi_pkg::SYM_BITS] = lane_sym[k];
      end
    end
  endgenerate

endmodule

`default_nettype wire

// ----- rtl/core/atsc_field_sync_inserter.sv -----
// ----------------------------------------------------------------------------
// atsc_field_sync_inserter: 8VSB field-sync segment insertion.
// A passed-through word is registered and appears in the cycle after it is
// accepted. Throughput: one word per cycle while out_stall is low; a word at
// group 0 of the first segment of a field is held and the input stalled while
// the 52 sync words go out first, then the held word itself follows.
// Reset returns to pass-through and zeroes out_valid and the kept tail symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module atsc_field_sync_inserter #(
  parameter int TAIL_SYMS = afsi_pkg::TAIL_SYMS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [afsi_pkg::WORD_BITS-1:0]       in_symbols,
  input  logic [afsi_pkg::GROUP_BITS-1:0]      group_index,
  input  logic                                 first_seg_of_field,
  input  logic                                 field_two,
  input  logic                                 last_seg_of_field,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [afsi_pkg::WORD_BITS-1:0]       out_symbols,
  output logic [afsi_pkg::GROUP_BITS-1:0]      out_group_index,
  output logic                                 is_field_sync,
  output logic                                 out_first_seg,
  output logic                                 out_field_two,
  output logic                                 out_last_seg,
  output logic                                 run_last
);

  localparam int TAIL_BITS = afsi_pkg::SYM_BITS * TAIL_SYMS;
  localparam logic [afsi_pkg::GROUP_BITS-1:0] SEG_END =
    afsi_pkg::GROUP_BITS'(afsi_pkg::SEG_GROUPS);

  typedef enum logic [1:0] {
    ST_PASS = 2'b01,
    ST_SYNC = 2'b10
  } state_t;

  state_t                             state;
  logic [afsi_pkg::GROUP_BITS-1:0]    cnt;
  logic [TAIL_BITS-1:0]               saved_tail;

  logic [afsi_pkg::WORD_BITS-1:0]     hold_symbols;
  logic [afsi_pkg::GROUP_BITS-1:0]    hold_group;
  logic                               hold_first;
  logic                               hold_field_two;
  logic                               hold_last;

  afsi_pkg::sync_req_t                sync_req;
  logic [afsi_pkg::WORD_BITS-1:0]     sync_word;

  logic out_free;
  logic in_acc;
  logic trigger;
  logic save_tail;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state == ST_SYNC) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign trigger   = first_seg_of_field && (group_index == '0);
  assign save_tail = !first_seg_of_field && last_seg_of_field &&
                     (group_index == afsi_pkg::LAST_GROUP);

  assign sync_req.group = cnt;
  assign sync_req.inv   = hold_field_two;

  afsi_sync_gen #(
    .TAIL_SYMS (TAIL_SYMS)
  ) u_sync_gen (
    .req  (sync_req),
    .tail (saved_tail),
    .word (sync_word)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PASS;
      cnt        <= '0;
      out_valid  <= 1'b0;
      saved_tail <= '0;
    end else begin
      unique case (state)
        ST_PASS: begin
          if (in_acc) begin
            if (trigger) begin
              state     <= ST_SYNC;
              cnt       <= '0;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              if (save_tail) begin
                saved_tail <= in_symbols[afsi_pkg::WORD_BITS-1 -: TAIL_BITS];
              end
            end
          end else if (out_free) begin
            out_valid <= 1'b0;
          end
        end
        ST_SYNC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            cnt       <= cnt + afsi_pkg::GROUP_BITS'(1);
            if (cnt == SEG_END) begin
              state <= ST_PASS;
            end
          end
        end
        default: begin
          state <= ST_PASS;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_PASS && in_acc) begin
      if (trigger) begin
        hold_symbols   <= in_symbols;
        hold_group     <= group_index;
        hold_first     <= first_seg_of_field;
        hold_field_two <= field_two;
        hold_last      <= last_seg_of_field;
      end else begin
        out_symbols     <= in_symbols;
        out_group_index <= group_index;
        is_field_sync   <= 1'b0;
        out_first_seg   <= first_seg_of_field;
        out_field_two   <= field_two;
        out_last_seg    <= last_seg_of_field;
        run_last        <= 1'b1;
      end
    end else if (state == ST_SYNC && out_free) begin
      if (cnt == SEG_END) begin
        // The held word goes out after the last sync word.
        out_symbols     <= hold_symbols;
        out_group_index <= hold_group;
        is_field_sync   <= 1'b0;
        out_first_seg   <= hold_first;
        out_field_two   <= hold_field_two;
        out_last_seg    <= hold_last;
        run_last        <= 1'b1;
      end else begin
        out_symbols     <= sync_word;
        out_group_index <= cnt;
        is_field_sync   <= 1'b1;
        out_first_seg   <= 1'b0;
        out_field_two   <= 1'b0;
        out_last_seg    <= 1'b0;
        run_last        <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
